/* rtl/core/qenc_pkg.sv */
`timescale 1ns / 1ps

package qenc_pkg;

  // Operation carried in the input tuser field
  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_START = 2'd1,
    OP_SET   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Click direction codes
  typedef enum logic [1:0] {
    CLICK_NONE = 2'd0,
    CLICK_UP   = 2'd1,
    CLICK_DOWN = 2'd2
  } click_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MIN_VALUE       = 2'd0,
    REG_MAX_VALUE       = 2'd1,
    REG_INITIAL_VALUE   = 2'd2,
    REG_HALF_PULSE_MODE = 2'd3
  } reg_index_t;

  localparam logic [2:0] DEC_RESET_STATE = 3'b011;
  localparam logic [2:0] DEC_HALF_BOTH_HIGH = 3'b111;
  localparam logic [1:0] PINS_BOTH_HIGH = 2'b11;

  // Transition entry: {step down, step up, next state[2:0]}
  typedef logic [4:0] trans_t;
  typedef trans_t trans_tab_t [8][4];

  // Columns: A falling, A rising, B falling, B rising
  localparam trans_tab_t PER_DETENT_TAB = '{
    '{5'd0, 5'd1,  5'd0, 5'd2},
    '{5'd0, 5'd1,  5'd1, 5'd11},   // B rising from state 1: up step to 3
    '{5'd2, 5'd3,  5'd0, 5'd2},
    '{5'd2, 5'd3,  5'd5, 5'd3},
    '{5'd4, 5'd5,  5'd4, 5'd6},
    '{5'd4, 5'd5,  5'd5, 5'd3},
    '{5'd6, 5'd19, 5'd4, 5'd6},    // A rising from state 6: down step to 3
    '{5'd3, 5'd3,  5'd3, 5'd3}
  };

  localparam trans_tab_t PER_TWO_TAB = '{
    '{5'd0,  5'd1,  5'd0, 5'd2},
    '{5'd0,  5'd1,  5'd1, 5'd15},  // up step to 7
    '{5'd2,  5'd23, 5'd0, 5'd2},   // down step to 7
    '{5'd7,  5'd7,  5'd7, 5'd7},
    '{5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd16, 5'd5,  5'd5, 5'd7},   // down step to 0
    '{5'd6,  5'd7,  5'd8, 5'd6},   // up step to 0
    '{5'd6,  5'd7,  5'd5, 5'd7}
  };

endpackage

/* rtl/core/quadrature_encoder_counter.sv */
`timescale 1ns / 1ps
// Quadrature encoder counter.
// Throughput: one item per cycle while the result stream is not stalled. The table
// lookup and clamped step sit between the input handshake and the result register,
// which captures each transfer's result; the state updates at transfer.
// Reset (rst, synchronous, active high): decoder inactive, state 3'b011, count
// zero, no pending change, configuration back to full range, per-detent table.
module quadrature_encoder_counter #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // edge_index[1:0], pin_a[2], pin_b[3], new_value[19:4]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // count_value[15:0], click[17:16], changed[18],
                                 // accepted[19]
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = COUNT_WIDTH;
  localparam logic signed [32:0] CNT_HI = (33'sd1 <<< (CW - 1)) - 33'sd1;
  localparam logic signed [32:0] CNT_LO = -CNT_HI - 33'sd1;

  // Saturate a 16-bit signed value into the count range
  function automatic logic signed [CW-1:0] fit16(input logic [15:0] v);
    logic signed [32:0] w;
    w = {{17{v[15]}}, v};
    if (w < CNT_LO) begin
      fit16 = CNT_LO[CW-1:0];
    end else if (w > CNT_HI) begin
      fit16 = CNT_HI[CW-1:0];
    end else begin
      fit16 = w[CW-1:0];
    end
  endfunction

  // configuration registers
  logic [15:0] min_value;
  logic [15:0] max_value;
  logic [15:0] initial_value;
  logic        half_pulse_mode;

  // decoder state
  logic [2:0]              decoder_state, decoder_state_next;
  logic signed [CW-1:0]    count, count_next;
  qenc_pkg::click_t        latched_click, latched_click_next;
  logic                    change_pending, change_pending_next;
  logic                    running, running_next;

  // result register
  logic [15:0]      res_count;
  qenc_pkg::click_t res_click, res_click_next;
  logic             res_changed, res_changed_next;
  logic             res_accepted, res_accepted_next;

  logic                 in_xfer;
  qenc_pkg::op_t        op;
  logic [1:0]           edge_index;
  logic [1:0]           pins;
  logic [15:0]          new_value;
  logic signed [CW-1:0] lim_lo, lim_hi, init_fit, set_fit;
  logic signed [CW-1:0] init_clamped, set_clamped;
  qenc_pkg::trans_t     entry;
  logic signed [32:0]   count_wide;

  assign cfg_ready = 1'b1;
  // Accept a new item whenever the result register is free or draining
  assign s_tready  = !m_tvalid || m_tready;
  assign in_xfer   = s_tvalid && s_tready;

  assign op         = qenc_pkg::op_t'(s_tuser);
  assign edge_index = s_tdata[1:0];
  assign pins       = {s_tdata[3], s_tdata[2]};
  assign new_value  = s_tdata[19:4];

  assign lim_lo   = fit16(min_value);
  assign lim_hi   = fit16(max_value);
  assign init_fit = fit16(initial_value);
  assign set_fit  = fit16(new_value);

  // Clamp against the limits; when they cross, values below the low limit get it, all others the high
  always_comb begin
    priority if (init_fit < lim_lo) begin
      init_clamped = lim_lo;
    end else if (init_fit > lim_hi) begin
      init_clamped = lim_hi;
    end else begin
      init_clamped = init_fit;
    end
    priority if (set_fit < lim_lo) begin
      set_clamped = lim_lo;
    end else if (set_fit > lim_hi) begin
      set_clamped = lim_hi;
    end else begin
      set_clamped = set_fit;
    end
  end

  // Look up the transition in the table of the current mode
  assign entry = half_pulse_mode ? qenc_pkg::PER_TWO_TAB[decoder_state][edge_index]
                                 : qenc_pkg::PER_DETENT_TAB[decoder_state][edge_index];

  always_comb begin
    decoder_state_next  = decoder_state;
    count_next          = count;
    latched_click_next  = latched_click;
    change_pending_next = change_pending;
    running_next        = running;
    res_click_next      = qenc_pkg::CLICK_NONE;
    res_changed_next    = 1'b0;
    res_accepted_next   = 1'b0;
    unique case (op)
      qenc_pkg::OP_EDGE: begin
        // Drop edges while inactive
        if (running) begin
          decoder_state_next = entry[2:0];
          res_accepted_next  = 1'b1;
          if (entry[3]) begin
            if (count < lim_hi) begin
              count_next = count + CW'(1);
            end
            latched_click_next  = qenc_pkg::CLICK_UP;
            change_pending_next = 1'b1;
            res_click_next      = qenc_pkg::CLICK_UP;
            res_changed_next    = 1'b1;
          end else if (entry[4]) begin
            if (count > lim_lo) begin
              count_next = count - CW'(1);
            end
            latched_click_next  = qenc_pkg::CLICK_DOWN;
            change_pending_next = 1'b1;
            res_click_next      = qenc_pkg::CLICK_DOWN;
            res_changed_next    = 1'b1;
          end
        end
      end
      qenc_pkg::OP_START: begin
        if (!running && (lim_lo < lim_hi)) begin
          // In half-pulse mode both pins high maps to the rest state 3'b111
          if (half_pulse_mode && (pins == qenc_pkg::PINS_BOTH_HIGH)) begin
            decoder_state_next = qenc_pkg::DEC_HALF_BOTH_HIGH;
          end else begin
            decoder_state_next = {1'b0, pins};
          end
          count_next          = init_clamped;
          latched_click_next  = qenc_pkg::CLICK_NONE;
          change_pending_next = 1'b0;
          running_next        = 1'b1;
          res_accepted_next   = 1'b1;
        end
      end
      qenc_pkg::OP_SET: begin
        count_next        = set_clamped;
        res_accepted_next = 1'b1;
      end
      qenc_pkg::OP_READ: begin
        if (change_pending) begin
          res_click_next   = latched_click;
          res_changed_next = 1'b1;
        end
        change_pending_next = 1'b0;
        res_accepted_next   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_value       <= 16'h8000;
      max_value       <= 16'h7FFF;
      initial_value   <= 16'h0000;
      half_pulse_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (qenc_pkg::reg_index_t'(cfg_index))
        qenc_pkg::REG_MIN_VALUE:       min_value       <= cfg_data;
        qenc_pkg::REG_MAX_VALUE:       max_value       <= cfg_data;
        qenc_pkg::REG_INITIAL_VALUE:   initial_value   <= cfg_data;
        qenc_pkg::REG_HALF_PULSE_MODE: half_pulse_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // decoder state advances on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      decoder_state  <= qenc_pkg::DEC_RESET_STATE;
      count          <= '0;
      latched_click  <= qenc_pkg::CLICK_NONE;
      change_pending <= 1'b0;
      running        <= 1'b0;
    end else if (in_xfer) begin
      decoder_state  <= decoder_state_next;
      count          <= count_next;
      latched_click  <= latched_click_next;
      change_pending <= change_pending_next;
      running        <= running_next;
    end
  end

  // show the low 16 bits of the sign-extended count
  assign count_wide = {{(33 - CW){count_next[CW-1]}}, count_next};

  // result register: hold until the downstream transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_count    <= count_wide[15:0];
      res_click    <= res_click_next;
      res_changed  <= res_changed_next;
      res_accepted <= res_accepted_next;
    end
  end

  assign m_tdata = {4'b0000, res_accepted, res_changed, res_click, res_count};

endmodule
